// File: hw/rtl/lru_pin_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU table with pinned entries: shared package
// Sizes, codes and the structs passed between the table's modules.
// ----------------------------------------------------------------------------
package lru_pin_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam int CW        = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W     = 64;
  localparam int MODE_W    = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [MODE_W-1:0] {
    MODE_REQUEST   = 2'd0,
    MODE_FRAME     = 2'd1,
    MODE_LOAD_DONE = 2'd2,
    MODE_XFER_DONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    mode_t            mode;
    logic [KEY_W-1:0] key;
    logic             load_empty;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] rd_idx;
    logic             cmp_vld;
    logic [IDX_W-1:0] cmp_idx;
    logic             commit;
  } ctrl_t;

  typedef struct packed {
    logic             hit;
    logic             has_data;
    logic             data_ready;
    logic             load_started;
    logic             refused;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/lru_pin_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU table with pinned entries: channel interfaces
// Valid/ready channels for input items, result items and the capacity write.
// ----------------------------------------------------------------------------
interface lru_pin_in_if;
  logic                          valid;
  logic                          ready;
  logic [lru_pin_pkg::MODE_W-1:0] mode;
  logic [lru_pin_pkg::KEY_W-1:0]  key;
  logic                          load_empty;

  modport source (output valid, mode, key, load_empty, input ready);
  modport sink   (input valid, mode, key, load_empty, output ready);
endinterface

interface lru_pin_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         has_data;
  logic                         data_ready;
  logic                         load_started;
  logic                         refused;
  logic                         evicted;
  logic [lru_pin_pkg::KEY_W-1:0] evicted_key;

  modport source (output valid, hit, has_data, data_ready, load_started, refused, evicted,
                  evicted_key, input ready);
  modport sink   (input valid, hit, has_data, data_ready, load_started, refused, evicted,
                  evicted_key, output ready);
endinterface

interface lru_pin_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lru_pin_pkg::CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lru_pin_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lru_pin_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/lru_pin_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU table with pinned entries: sequencer
// Tag-compares every entry (frame items skip this), then commits the update.
// ----------------------------------------------------------------------------
module lru_pin_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_acc,
  input  wire logic                is_frame,
  input  wire logic                out_free,
  output logic                     in_ready,
  output lru_pin_pkg::ctrl_t       ctrl
);
  import lru_pin_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             scan_last;

  assign scan_last = (scan_idx_r == IDX_W'(ENTRIES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = is_frame ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    if (in_acc) begin
      scan_idx_nxt = '0;
    end else if (state_r == ST_SCAN) begin
      scan_idx_nxt = scan_idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    ctrl.start   = in_acc;
    ctrl.rd_idx  = scan_idx_r;
    ctrl.cmp_vld = cmp_vld_r;
    ctrl.cmp_idx = cmp_idx_r;
    ctrl.commit  = (state_r == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      cmp_vld_r  <= (state_r == ST_SCAN);
    end
  end

  // The tag RAM registers its read data, so the compare index is registered
  // from the read index and trails it by one entry.
  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
  end

endmodule
`default_nettype wire

// File: hw/rtl/lru_pin_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU table with pinned entries: entry table
// Tag RAM, per-entry flags and recency ranks, the shared tag compare and the
// commit of each item's update.
// ----------------------------------------------------------------------------
module lru_pin_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lru_pin_pkg::ctrl_t            ctrl,
  input  wire lru_pin_pkg::item_t            item,
  input  wire logic [lru_pin_pkg::CAP_W-1:0] capacity,
  output lru_pin_pkg::result_t               result
);
  import lru_pin_pkg::*;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] loading_r, loading_nxt;
  logic [ENTRIES-1:0] holds_r, holds_nxt;
  logic [ENTRIES-1:0] ready_r, ready_nxt;
  logic [ENTRIES-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]   rank_r [ENTRIES];
  logic [IDX_W-1:0]   rank_nxt [ENTRIES];
  logic [CNT_W-1:0]   occ_r, occ_nxt;

  logic [KEY_W-1:0]   tag_rdata;
  logic               tag_we;
  logic [IDX_W-1:0]   slot;

  // Results of the scan.
  logic               found_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [IDX_W-1:0]   hit_rank_r;
  logic               hit_loading_r;
  logic               hit_holds_r;
  logic               hit_ready_r;
  logic [IDX_W-1:0]   lru_idx_r;
  logic [KEY_W-1:0]   lru_tag_r;
  logic               lru_pin_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;

  logic               cur_valid;
  logic               tag_match;
  logic               is_lru;
  logic               take_hit;
  logic               take_free;
  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      eff_cap;
  logic               full;
  logic               is_req;
  logic               refuse;
  logic               evict;
  logic               insert;

  lru_pin_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (slot),
    .wdata (item.key),
    .raddr (ctrl.rd_idx),
    .rdata (tag_rdata)
  );

  assign cur_valid = valid_r[ctrl.cmp_idx];
  assign tag_match = cur_valid && (tag_rdata == item.key);
  assign is_lru    = cur_valid &&
                     ((CNT_W'(rank_r[ctrl.cmp_idx]) + CNT_W'(1)) == occ_r);
  assign take_hit  = ctrl.cmp_vld && tag_match && !found_r;
  assign take_free = ctrl.cmp_vld && !cur_valid && !free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ctrl.start) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (take_hit) begin
        found_r <= 1'b1;
      end
      if (take_free) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx_r     <= ctrl.cmp_idx;
      hit_rank_r    <= rank_r[ctrl.cmp_idx];
      hit_loading_r <= loading_r[ctrl.cmp_idx];
      hit_holds_r   <= holds_r[ctrl.cmp_idx];
      hit_ready_r   <= ready_r[ctrl.cmp_idx];
    end
    if (ctrl.cmp_vld && is_lru) begin
      lru_idx_r <= ctrl.cmp_idx;
      lru_tag_r <= tag_rdata;
      // An entry is pinned while it loads, waits on a transfer or was used
      // in the current frame.
      lru_pin_r <= loading_r[ctrl.cmp_idx] ||
                   (holds_r[ctrl.cmp_idx] && !ready_r[ctrl.cmp_idx]) ||
                   used_r[ctrl.cmp_idx];
    end
    if (take_free) begin
      free_idx_r <= ctrl.cmp_idx;
    end
  end

  // Capacity of zero acts as one, anything above the table size as the size.
  always_comb begin
    cap_ext = CW'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full   = (CW'(occ_r) >= eff_cap);
  assign is_req = (item.mode == MODE_REQUEST);
  assign refuse = is_req && !found_r && full && lru_pin_r;
  assign evict  = is_req && !found_r && full && !lru_pin_r;
  assign insert = is_req && !found_r && !refuse;
  assign tag_we = ctrl.commit && insert;

  // The insert takes the lowest free entry, which may be the one just evicted.
  assign slot = (evict && (!free_found_r || (lru_idx_r < free_idx_r))) ? lru_idx_r
                                                                        : free_idx_r;

  always_comb begin
    valid_nxt   = valid_r;
    loading_nxt = loading_r;
    holds_nxt   = holds_r;
    ready_nxt   = ready_r;
    used_nxt    = used_r;
    occ_nxt     = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (ctrl.commit) begin
      unique case (item.mode)
        MODE_REQUEST: begin
          if (found_r) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
                rank_nxt[i] = rank_r[i] + IDX_W'(1);
              end
            end
            rank_nxt[hit_idx_r] = '0;
            used_nxt[hit_idx_r] = 1'b1;
          end else if (!refuse) begin
            if (evict) begin
              valid_nxt[lru_idx_r]   = 1'b0;
              loading_nxt[lru_idx_r] = 1'b0;
              holds_nxt[lru_idx_r]   = 1'b0;
              ready_nxt[lru_idx_r]   = 1'b0;
              used_nxt[lru_idx_r]    = 1'b0;
            end
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_r[i]) begin
                rank_nxt[i] = rank_r[i] + IDX_W'(1);
              end
            end
            valid_nxt[slot]   = 1'b1;
            loading_nxt[slot] = 1'b1;
            holds_nxt[slot]   = 1'b0;
            ready_nxt[slot]   = 1'b0;
            used_nxt[slot]    = 1'b1;
            rank_nxt[slot]    = '0;
            if (!evict) begin
              occ_nxt = occ_r + CNT_W'(1);
            end
          end
        end
        MODE_FRAME: begin
          used_nxt = '0;
        end
        MODE_LOAD_DONE: begin
          if (found_r && hit_loading_r) begin
            loading_nxt[hit_idx_r] = 1'b0;
            holds_nxt[hit_idx_r]   = !item.load_empty;
          end
        end
        MODE_XFER_DONE: begin
          if (found_r && !hit_loading_r && hit_holds_r) begin
            ready_nxt[hit_idx_r] = 1'b1;
          end
        end
        default: begin
          used_nxt = used_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      loading_r <= '0;
      holds_r   <= '0;
      ready_r   <= '0;
      used_r    <= '0;
      occ_r     <= '0;
    end else begin
      valid_r   <= valid_nxt;
      loading_r <= loading_nxt;
      holds_r   <= holds_nxt;
      ready_r   <= ready_nxt;
      used_r    <= used_nxt;
      occ_r     <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
  end

  always_comb begin
    result.hit          = is_req && found_r;
    result.has_data     = is_req && found_r && hit_holds_r;
    result.data_ready   = is_req && found_r && hit_holds_r && hit_ready_r;
    result.load_started = insert;
    result.refused      = refuse;
    result.evicted      = evict;
    result.evicted_key  = evict ? lru_tag_r : '0;
  end

endmodule
`default_nettype wire

// File: hw/rtl/lru_cache_with_pinned_entries_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU table with pinned entries: top level
// Fully associative LRU table keyed by a 64-bit id, with pinned entries.
// ----------------------------------------------------------------------------
// A request, load done or transfer done item scans every entry, then passes
// the drain and finish states; a frame start item goes straight to finish,
// which waits for a free output register. The one tag comparator reads the
// tag RAM one entry per cycle and checks every entry before the update is
// committed. Every item gives exactly one result item, held in an output
// register until taken; a new item may be accepted while it waits. The
// capacity register is written through the configuration channel, which is
// always ready, and should only change while the block is idle.
module lru_cache_with_pinned_entries_top (
  input  wire logic     clk,
  input  wire logic     rst_n,
  lru_pin_in_if.sink    in_ch,
  lru_pin_out_if.source out_ch,
  lru_pin_cfg_if.sink   cfg_ch
);
  import lru_pin_pkg::*;

  logic             in_acc;
  logic             in_ready;
  logic             out_free;
  logic             is_frame;
  item_t            item_r;
  ctrl_t            ctrl;
  result_t          result;
  result_t          res_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CAP_W-1:0] capacity_r;

  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid && in_ready;
  assign is_frame     = (mode_t'(in_ch.mode) == MODE_FRAME);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_ch.valid) begin
      capacity_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.mode       <= mode_t'(in_ch.mode);
      item_r.key        <= in_ch.key;
      item_r.load_empty <= in_ch.load_empty;
    end
  end

  lru_pin_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .is_frame (is_frame),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  lru_pin_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .item     (item_r),
    .capacity (capacity_r),
    .result   (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      res_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = res_r.hit;
  assign out_ch.has_data     = res_r.has_data;
  assign out_ch.data_ready   = res_r.data_ready;
  assign out_ch.load_started = res_r.load_started;
  assign out_ch.refused      = res_r.refused;
  assign out_ch.evicted      = res_r.evicted;
  assign out_ch.evicted_key  = res_r.evicted_key;

endmodule
`default_nettype wire

// File: hw/rtl/lru_pin_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU table with pinned entries: port checker
// Checks the result channel and the input handshake as seen at the ports.
// ----------------------------------------------------------------------------
module lru_pin_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_hit,
  input wire logic                          out_has_data,
  input wire logic                          out_data_ready,
  input wire logic                          out_load_started,
  input wire logic                          out_refused,
  input wire logic                          out_evicted,
  input wire logic [lru_pin_pkg::KEY_W-1:0] out_evicted_key
);

  // A waiting result item is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // One item is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an item was accepted");

  a_data_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> !out_has_data && !out_data_ready)
    else $error("data flags set without a hit");

  // An eviction only happens to make room for a new entry.
  a_evict_inserts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_load_started && !out_hit && !out_refused)
    else $error("eviction without an insert");

  a_evicted_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == '0)
    else $error("evicted key set without an eviction");

endmodule

bind lru_cache_with_pinned_entries_top lru_pin_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_hit          (out_ch.hit),
  .out_has_data     (out_ch.has_data),
  .out_data_ready   (out_ch.data_ready),
  .out_load_started (out_ch.load_started),
  .out_refused      (out_ch.refused),
  .out_evicted      (out_ch.evicted),
  .out_evicted_key  (out_ch.evicted_key)
);
`default_nettype wire

// File: dv/lru_cache_with_pinned_entries_top_tb.sv
// ----------------------------------------------------------------------------
// LRU table with pinned entries: testbench
// Drives request, frame start, load done and transfer done items into the
// table under several capacity settings and handshake mixes. A scoreboard
// keeps its own copy of the table, predicts the result of every accepted item
// and compares each returned result item with it, field by field.
// ----------------------------------------------------------------------------
module lru_cache_with_pinned_entries_top_tb;
  import lru_pin_pkg::*;

  localparam int SETTLE      = ENTRIES + 4;
  localparam int HOLD_LEN    = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 30;

  localparam logic [KEY_W-1:0] KEY_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_EDGE = 64'h8000_0000_0000_0001;
  localparam logic [KEY_W-1:0] KEY_MIX  = 64'h5A5A_A5A5_0F0F_F0F0;

  class lru_scoreboard;
    logic [KEY_W-1:0] tags [ENTRIES];
    bit               live [ENTRIES];
    bit               loading [ENTRIES];
    bit               has_buf [ENTRIES];
    bit               xfer_ok [ENTRIES];
    bit               used [ENTRIES];
    int unsigned      rank [ENTRIES];
    int unsigned      occ;
    logic [CAP_W-1:0] cap;
    result_t          pending [$];
    int               errors;
    int               checked;
    int               hits;
    int               loads;
    int               evictions;
    int               refusals;

    function void clear();
      for (int i = 0; i < ENTRIES; i++) begin
        tags[i]    = '0;
        live[i]    = 1'b0;
        loading[i] = 1'b0;
        has_buf[i] = 1'b0;
        xfer_ok[i] = 1'b0;
        used[i]    = 1'b0;
        rank[i]    = 0;
      end
      occ = 0;
      cap = CAP_RESET;
      pending.delete();
      errors = 0;
      checked = 0;
      hits = 0;
      loads = 0;
      evictions = 0;
      refusals = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      cap = v;
    endfunction

    function int unsigned eff_cap();
      if (cap == 0) return 1;
      if (cap > ENTRIES) return ENTRIES;
      return cap;
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    function int find_tag(logic [KEY_W-1:0] k);
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && tags[i] == k) return i;
      return -1;
    endfunction

    function void serve_request(input logic [KEY_W-1:0] k, inout result_t r);
      int          h;
      int          victim;
      int          slot;
      int unsigned old_rank;
      h = find_tag(k);
      if (h >= 0) begin
        old_rank = rank[h];
        for (int i = 0; i < ENTRIES; i++)
          if (live[i] && rank[i] < old_rank) rank[i]++;
        rank[h] = 0;
        used[h] = 1'b1;
        r.hit = 1'b1;
        r.has_data = has_buf[h];
        r.data_ready = has_buf[h] && xfer_ok[h];
        return;
      end
      if (occ >= eff_cap()) begin
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (live[i] && rank[i] + 1 == occ) victim = i;
        if (victim < 0) return;
        // The oldest entry is pinned while loading, while its data waits on the
        // transfer, or once it has been touched in the current frame.
        if (loading[victim] || (has_buf[victim] && !xfer_ok[victim]) || used[victim]) begin
          r.refused = 1'b1;
          return;
        end
        r.evicted = 1'b1;
        r.evicted_key = tags[victim];
        live[victim] = 1'b0;
        loading[victim] = 1'b0;
        has_buf[victim] = 1'b0;
        xfer_ok[victim] = 1'b0;
        used[victim] = 1'b0;
        occ--;
      end
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (live[i]) rank[i]++;
        else if (slot < 0) slot = i;
      end
      if (slot < 0) return;
      tags[slot] = k;
      live[slot] = 1'b1;
      loading[slot] = 1'b1;
      has_buf[slot] = 1'b0;
      xfer_ok[slot] = 1'b0;
      used[slot] = 1'b1;
      rank[slot] = 0;
      occ++;
      r.load_started = 1'b1;
    endfunction

    function void note_item(item_t it);
      result_t r;
      int      e;
      r = '0;
      case (it.mode)
        MODE_REQUEST: begin
          serve_request(it.key, r);
        end
        MODE_FRAME: begin
          for (int i = 0; i < ENTRIES; i++) used[i] = 1'b0;
        end
        MODE_LOAD_DONE: begin
          e = find_tag(it.key);
          if (e >= 0 && loading[e]) begin
            loading[e] = 1'b0;
            has_buf[e] = !it.load_empty;
          end
        end
        default: begin
          e = find_tag(it.key);
          if (e >= 0 && !loading[e] && has_buf[e]) xfer_ok[e] = 1'b1;
        end
      endcase
      hits += r.hit;
      loads += r.load_started;
      evictions += r.evicted;
      refusals += r.refused;
      pending = {pending, r};
    endfunction

    function void check_result(result_t got);
      result_t          want;
      string            names [7];
      logic [KEY_W-1:0] w [7];
      logic [KEY_W-1:0] g [7];
      names = '{"hit", "has_data", "data_ready", "load_started", "refused", "evicted",
                "evicted_key"};
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result item %0d arrived with nothing expected", $time, checked);
        return;
      end
      want = pending.pop_front();
      w = '{want.hit, want.has_data, want.data_ready, want.load_started, want.refused,
            want.evicted, want.evicted_key};
      g = '{got.hit, got.has_data, got.data_ready, got.load_started, got.refused,
            got.evicted, got.evicted_key};
      for (int i = 0; i < 7; i++) begin
        if (g[i] !== w[i]) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result %0d %s expected %0h actual %0h", $time, checked,
                     names[i], w[i], g[i]);
        end
      end
    endfunction

    // Picks the id of some resident entry, so that load and transfer completions
    // mostly land on entries that can react to them.
    function bit resident_key(output logic [KEY_W-1:0] k);
      int picks [$];
      for (int i = 0; i < ENTRIES; i++)
        if (live[i]) picks = {picks, i};
      k = '0;
      if (picks.size() == 0) return 1'b0;
      k = tags[picks[$urandom_range(picks.size() - 1)]];
      return 1'b1;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  lru_pin_in_if  in_ch ();
  lru_pin_out_if out_ch ();
  lru_pin_cfg_if cfg_ch ();

  lru_cache_with_pinned_entries_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lru_scoreboard    sb;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               hold_asked = 0;
  int               cap_writes = 0;
  int               items_sent = 0;
  logic [KEY_W-1:0] pool [24];
  int               pool_n = 1;

  // Both channels are sampled at the rising edge; results are checked before
  // the item accepted at the same edge is added.
  always @(posedge clk) begin
    result_t got;
    item_t   seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.hit = out_ch.hit;
        got.has_data = out_ch.has_data;
        got.data_ready = out_ch.data_ready;
        got.load_started = out_ch.load_started;
        got.refused = out_ch.refused;
        got.evicted = out_ch.evicted;
        got.evicted_key = out_ch.evicted_key;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.mode = mode_t'(in_ch.mode);
        seen.key = in_ch.key;
        seen.load_empty = in_ch.load_empty;
        sb.note_item(seen);
        items_sent++;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin : result_sink
    int stall_left;
    int served;
    stall_left = 0;
    served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != served) begin
        served++;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("lru_cache_with_pinned_entries_top verification failed");
    $finish;
  end

  task automatic offer(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= it.mode;
    in_ch.key <= it.key;
    in_ch.load_empty <= it.load_empty;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic offer_op(input mode_t m, input logic [KEY_W-1:0] k, input logic empty);
    item_t it;
    it.mode = m;
    it.key = k;
    it.load_empty = empty;
    offer(it);
  endtask

  // Waits out every expected result and then the block's own latency, so a
  // capacity write that follows lands on an idle block.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.set_capacity(v);
    cap_writes++;
  endtask

  // A few more ids than the table can hold, so that hits and misses both occur.
  task automatic fill_pool();
    pool_n = sb.eff_cap() + 4;
    for (int i = 0; i < pool_n; i++) pool[i] = {$urandom, $urandom};
    if ($urandom_range(1)) begin
      pool[0] = KEY_ZERO;
      pool[1] = KEY_ONES;
    end
  endtask

  task automatic random_items(input int count);
    item_t            it;
    logic [KEY_W-1:0] k;
    int               r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      it.key = pool[$urandom_range(pool_n - 1)];
      it.load_empty = ($urandom_range(3) == 0);
      if (r < 45) begin
        it.mode = MODE_REQUEST;
      end else if (r < 89) begin
        it.mode = (r < 67) ? MODE_LOAD_DONE : MODE_XFER_DONE;
        if ($urandom_range(99) < 85 && sb.resident_key(k)) it.key = k;
      end else if (r < 96) begin
        it.mode = MODE_FRAME;
        it.key = {$urandom, $urandom};
      end else begin
        // Completions for ids that are almost surely not resident.
        it.mode = $urandom_range(1) ? MODE_LOAD_DONE : MODE_XFER_DONE;
        it.key = {$urandom, $urandom};
      end
      offer(it);
    end
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] capv, input int s_pct, input int r_pct,
                           input int count);
    drain();
    write_capacity(capv);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    fill_pool();
    random_items(count);
  endtask

  initial begin : main
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_REQUEST;
    in_ch.key <= '0;
    in_ch.load_empty <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    sb = new;
    sb.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk through a two-entry table.
    write_capacity(5'd2);
    offer_op(MODE_REQUEST,   KEY_ZERO, 1'b0);
    offer_op(MODE_REQUEST,   KEY_ZERO, 1'b0);
    offer_op(MODE_LOAD_DONE, KEY_ZERO, 1'b0);
    offer_op(MODE_REQUEST,   KEY_ZERO, 1'b0);
    offer_op(MODE_XFER_DONE, KEY_ZERO, 1'b0);
    offer_op(MODE_REQUEST,   KEY_ZERO, 1'b0);
    offer_op(MODE_REQUEST,   KEY_ONES, 1'b1);
    offer_op(MODE_REQUEST,   KEY_EDGE, 1'b0);
    offer_op(MODE_FRAME,     KEY_ONES, 1'b1);
    offer_op(MODE_REQUEST,   KEY_EDGE, 1'b0);
    offer_op(MODE_LOAD_DONE, KEY_ONES, 1'b1);
    offer_op(MODE_XFER_DONE, KEY_ONES, 1'b0);
    offer_op(MODE_LOAD_DONE, KEY_ONES, 1'b0);
    offer_op(MODE_LOAD_DONE, KEY_MIX,  1'b0);
    offer_op(MODE_XFER_DONE, KEY_EDGE, 1'b0);
    offer_op(MODE_FRAME,     KEY_ZERO, 1'b0);
    offer_op(MODE_REQUEST,   KEY_EDGE, 1'b0);
    offer_op(MODE_REQUEST,   KEY_MIX,  1'b0);
    offer_op(MODE_LOAD_DONE, KEY_EDGE, 1'b0);
    offer_op(MODE_FRAME,     KEY_MIX,  1'b0);
    offer_op(MODE_REQUEST,   KEY_ZERO, 1'b0);
    offer_op(MODE_XFER_DONE, KEY_EDGE, 1'b0);
    offer_op(MODE_REQUEST,   KEY_ZERO, 1'b0);
    offer_op(MODE_XFER_DONE, KEY_EDGE, 1'b0);

    run_phase(5'd16, 0, 0, 150);
    run_phase(5'd31, 53, 0, 150);

    // Capacity drops below the current occupancy; the result side then holds
    // off long enough for the input to back up.
    run_phase(5'd3, 0, 53, 40);
    hold_asked++;
    random_items(110);

    // Capacity zero; the sender pauses midway until the table has answered.
    run_phase(5'd0, 33, 33, 60);
    drain();
    random_items(60);

    run_phase(5'd1, 0, 0, 100);
    run_phase(5'd8, 33, 33, 150);
    run_phase(5'd5, 53, 0, 130);
    drain();

    $display("Checked %0d results for %0d items: %0d hits, %0d loads, %0d evictions, %0d refusals.",
             sb.checked, items_sent, sb.hits, sb.loads, sb.evictions, sb.refusals);
    $display("Capacity written %0d times (0 to 31), under four stall mixes with a long hold-off.",
             cap_writes);
    if (sb.errors == 0) begin
      $display("lru_cache_with_pinned_entries_top verification clean");
    end else begin
      $display("lru_cache_with_pinned_entries_top verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lru_pin_pkg.sv
hw/rtl/lru_pin_if.sv
hw/rtl/lru_pin_ram.sv
hw/rtl/lru_pin_ctrl.sv
hw/rtl/lru_pin_table.sv
hw/rtl/lru_cache_with_pinned_entries_top.sv
hw/rtl/lru_pin_checker.sv
dv/lru_cache_with_pinned_entries_top_tb.sv
